[design/pvt_pkg.sv]
package pvt_pkg;

    localparam int COORD_WIDTH_DEF        = 16;
    localparam int TRIG_FRACTION_BITS_DEF = 14;

    localparam int TRIG_W     = 16;
    localparam int FOCAL_W    = 12;
    localparam int EYE_W      = 16;
    localparam int CENTER_W   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [TRIG_W-1:0]   COS_Z_RST  = 16'd16384;
    localparam logic [TRIG_W-1:0]   SIN_Z_RST  = 16'd0;
    localparam logic [TRIG_W-1:0]   COS_X_RST  = 16'd16384;
    localparam logic [TRIG_W-1:0]   SIN_X_RST  = 16'd0;
    localparam logic [FOCAL_W-1:0]  FOCAL_RST  = 12'd800;
    localparam logic [EYE_W-1:0]    EYE_RST    = 16'd640;
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 12'd400;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 12'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_Z    = 4'd0,
        REG_SIN_Z    = 4'd1,
        REG_COS_X    = 4'd2,
        REG_SIN_X    = 4'd3,
        REG_FOCAL    = 4'd4,
        REG_EYE_DIST = 4'd5,
        REG_CENTER_X = 4'd6,
        REG_CENTER_Y = 4'd7
    } reg_idx_t;

    // status that rides along the divider chain
    typedef struct packed {
        logic behind;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } div_flags_t;

    function automatic int max2(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

[design/pvt_vertex_if.sv]
interface pvt_vertex_if #(
    parameter int W = pvt_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] vertex_x;
    logic signed [W-1:0] vertex_y;
    logic signed [W-1:0] vertex_z;

    modport source (output valid, output vertex_x, output vertex_y, output vertex_z,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input vertex_z,
                    output ready);
endinterface

[design/pvt_screen_if.sv]
interface pvt_screen_if #(
    parameter int W = pvt_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] screen_x;
    logic signed [W-1:0] screen_y;
    logic                behind_eye;
    logic                clipped;

    modport source (output valid, output screen_x, output screen_y, output behind_eye,
                    output clipped, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input behind_eye,
                    input clipped, output ready);
endinterface

[design/pvt_cfg_if.sv]
interface pvt_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pvt_pkg::CFG_IDX_W-1:0]   index;
    logic [pvt_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/pvt_rotate.sv]
module pvt_rotate #(
    parameter int C  = pvt_pkg::COORD_WIDTH_DEF,
    parameter int T  = pvt_pkg::TRIG_FRACTION_BITS_DEF,
    parameter int P1 = C + pvt_pkg::TRIG_W + 1,
    parameter int P2 = P1 + pvt_pkg::TRIG_W + 1,
    parameter int DW = P2 + 1
) (
    input  logic                               clk,
    input  logic [3:0]                         en,
    input  logic signed [C-1:0]                vx,
    input  logic signed [C-1:0]                vy,
    input  logic signed [C-1:0]                vz,
    input  logic signed [pvt_pkg::TRIG_W-1:0]  cz,
    input  logic signed [pvt_pkg::TRIG_W-1:0]  sz,
    input  logic signed [pvt_pkg::TRIG_W-1:0]  cx,
    input  logic signed [pvt_pkg::TRIG_W-1:0]  sx,
    input  logic [pvt_pkg::EYE_W-1:0]          ed,
    output logic signed [P1-1:0]               x1_out,
    output logic signed [P2-1:0]               y2_out,
    output logic signed [DW-1:0]               den_out
);
    localparam int TW = pvt_pkg::TRIG_W;

    // products of the Z rotation
    logic signed [C+TW-1:0] pxc_reg, pys_reg, pxs_reg, pyc_reg;
    logic signed [C-1:0]    z1_reg;
    // Z rotation sums
    logic signed [P1-1:0]   x1a_reg, y1_reg;
    logic signed [C-1:0]    z2_reg;
    // products of the X rotation
    logic signed [P1+TW-1:0] ycx_reg, ysx_reg;
    logic signed [C+TW-1:0]  zsx_reg, zcx_reg;
    logic signed [P1-1:0]    x1b_reg;
    // X rotation sums and depth
    logic signed [P1-1:0]   x1c_reg;
    logic signed [P2-1:0]   y2_reg;
    logic signed [DW-1:0]   den_reg;

    logic signed [P1-1:0]   x1_next, y1_next;
    logic signed [P2-1:0]   y2_next, z2_next;
    logic signed [DW-1:0]   den_next;

    always_comb
    begin
        x1_next  = P1'(pxc_reg) - P1'(pys_reg);
        y1_next  = P1'(pxs_reg) + P1'(pyc_reg);
        y2_next  = P2'(ycx_reg) - (P2'(zsx_reg) <<< T);
        z2_next  = P2'(ysx_reg) + (P2'(zcx_reg) <<< T);
        den_next = DW'(z2_next) + (DW'($signed({1'b0, ed})) <<< (2 * T));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pxc_reg <= vx * cz;
            pys_reg <= vy * sz;
            pxs_reg <= vx * sz;
            pyc_reg <= vy * cz;
            z1_reg  <= vz;
        end
        if (en[1])
        begin
            x1a_reg <= x1_next;
            y1_reg  <= y1_next;
            z2_reg  <= z1_reg;
        end
        if (en[2])
        begin
            ycx_reg <= y1_reg * cx;
            ysx_reg <= y1_reg * sx;
            zsx_reg <= z2_reg * sx;
            zcx_reg <= z2_reg * cx;
            x1b_reg <= x1a_reg;
        end
        if (en[3])
        begin
            x1c_reg <= x1b_reg;
            y2_reg  <= y2_next;
            den_reg <= den_next;
        end
    end

    assign x1_out  = x1c_reg;
    assign y2_out  = y2_reg;
    assign den_out = den_reg;
endmodule

[design/pvt_project.sv]
module pvt_project #(
    parameter int T  = pvt_pkg::TRIG_FRACTION_BITS_DEF,
    parameter int P1 = 33,
    parameter int P2 = 50,
    parameter int DW = 52,
    parameter int NW = 66,
    parameter int RW = 83,
    parameter int QB = 17
) (
    input  logic                                clk,
    input  logic [2:0]                          en,
    input  logic signed [P1-1:0]                x1,
    input  logic signed [P2-1:0]                y2,
    input  logic signed [DW-1:0]                den,
    input  logic [pvt_pkg::FOCAL_W-1:0]         focal,
    input  logic [pvt_pkg::CENTER_W-1:0]        center_x,
    input  logic [pvt_pkg::CENTER_W-1:0]        center_y,
    output logic [RW-1:0]                       mag_x,
    output logic [RW-1:0]                       mag_y,
    output logic [DW-2:0]                       den_pos,
    output pvt_pkg::div_flags_t                 flags
);
    localparam int FW  = pvt_pkg::FOCAL_W;
    localparam int CTW = pvt_pkg::CENTER_W;

    logic signed [FW+P1:0]    fx_reg;
    logic signed [FW+P2:0]    fy_reg;
    logic signed [CTW+DW:0]   cxd_reg, cyd_reg;
    logic signed [DW-1:0]     den5_reg, den6_reg;
    logic signed [NW-1:0]     nx_reg, ny_reg;
    logic [RW-1:0]            magx_reg, magy_reg;
    logic [DW-2:0]            denp_reg;
    pvt_pkg::div_flags_t      flags_reg;

    logic [NW-1:0]            ax, ay;
    logic [RW-1:0]            dlim;
    pvt_pkg::div_flags_t      flags_next;

    always_comb
    begin
        ax   = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        ay   = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        dlim = RW'(den6_reg[DW-2:0]) << QB;
        flags_next.behind = !(den6_reg > 0);
        flags_next.neg_x  = nx_reg[NW-1];
        flags_next.neg_y  = ny_reg[NW-1];
        flags_next.ovf_x  = RW'(ax) >= dlim;
        flags_next.ovf_y  = RW'(ay) >= dlim;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fx_reg   <= $signed({1'b0, focal}) * x1;
            fy_reg   <= $signed({1'b0, focal}) * y2;
            cxd_reg  <= $signed({1'b0, center_x}) * den;
            cyd_reg  <= $signed({1'b0, center_y}) * den;
            den5_reg <= den;
        end
        if (en[1])
        begin
            nx_reg   <= (NW'(fx_reg) <<< T) + NW'(cxd_reg);
            ny_reg   <= NW'(fy_reg) + NW'(cyd_reg);
            den6_reg <= den5_reg;
        end
        if (en[2])
        begin
            magx_reg  <= RW'(ax);
            magy_reg  <= RW'(ay);
            denp_reg  <= den6_reg[DW-2:0];
            flags_reg <= flags_next;
        end
    end

    assign mag_x   = magx_reg;
    assign mag_y   = magy_reg;
    assign den_pos = denp_reg;
    assign flags   = flags_reg;
endmodule

[design/pvt_div_cell.sv]
module pvt_div_cell #(
    parameter int RW    = 83,
    parameter int DPW   = 51,
    parameter int QB    = 17,
    parameter int SHIFT = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [RW-1:0]        rem_x_in,
    input  logic [RW-1:0]        rem_y_in,
    input  logic [QB-1:0]        q_x_in,
    input  logic [QB-1:0]        q_y_in,
    input  logic [DPW-1:0]       den_in,
    input  pvt_pkg::div_flags_t  flags_in,
    output logic [RW-1:0]        rem_x_out,
    output logic [RW-1:0]        rem_y_out,
    output logic [QB-1:0]        q_x_out,
    output logic [QB-1:0]        q_y_out,
    output logic [DPW-1:0]       den_out,
    output pvt_pkg::div_flags_t  flags_out
);
    logic [RW-1:0]       dsh;
    logic                gx, gy;
    logic [RW-1:0]       rx_next, ry_next;
    logic [QB-1:0]       qx_next, qy_next;
    logic [RW-1:0]       rx_reg, ry_reg;
    logic [QB-1:0]       qx_reg, qy_reg;
    logic [DPW-1:0]      den_reg;
    pvt_pkg::div_flags_t flags_reg;

    // one restoring step per lane
    always_comb
    begin
        dsh     = RW'(den_in) << SHIFT;
        gx      = rem_x_in >= dsh;
        gy      = rem_y_in >= dsh;
        rx_next = gx ? rem_x_in - dsh : rem_x_in;
        ry_next = gy ? rem_y_in - dsh : rem_y_in;
        qx_next = q_x_in;
        qy_next = q_y_in;
        qx_next[SHIFT] = gx;
        qy_next[SHIFT] = gy;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            den_reg   <= den_in;
            flags_reg <= flags_in;
        end
    end

    assign rem_x_out = rx_reg;
    assign rem_y_out = ry_reg;
    assign q_x_out   = qx_reg;
    assign q_y_out   = qy_reg;
    assign den_out   = den_reg;
    assign flags_out = flags_reg;
endmodule

[design/perspective_vertex_transform.sv]
// Perspective vertex transform: rotates each vertex about Z, then about X,
// and projects it onto the screen as trunc(focal*x1/den + centre), with
// saturation to the coordinate range and a behind_eye flag when the depth
// plus eye distance is not positive. One vertex beat is taken every clock
// cycle unless all stages are full and the output is stalled. The divider
// is a chain of COORD_WIDTH + 1 cells each producing one quotient bit of
// both screen coordinates, behind four rotation stages and three
// projection stages and ahead of the output register. Each stage moves on
// whenever the stage after it is empty or moving, so bubbles collapse and
// the input keeps flowing while a finished result waits at the output.
// There is no clearing pass after reset.
// Configuration writes are taken at any time and must land while idle.
module perspective_vertex_transform #(
    parameter int COORD_WIDTH        = pvt_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRACTION_BITS = pvt_pkg::TRIG_FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pvt_cfg_if.sink      cfg,
    pvt_vertex_if.sink   vertex,
    pvt_screen_if.source screen
);
    localparam int C   = COORD_WIDTH;
    localparam int T   = TRIG_FRACTION_BITS;
    localparam int TW  = pvt_pkg::TRIG_W;
    // rotated x and y, then X-rotated y and depth
    localparam int P1  = C + TW + 1;
    localparam int P2  = pvt_pkg::max2(P1 + TW, C + TW + T) + 1;
    localparam int DW  = pvt_pkg::max2(P2, pvt_pkg::EYE_W + 2 * T + 1) + 1;
    // projected numerators
    localparam int NA  = pvt_pkg::FOCAL_W + 1 + P1 + T;
    localparam int NB  = pvt_pkg::CENTER_W + 1 + DW;
    localparam int NC  = pvt_pkg::FOCAL_W + 1 + P2;
    localparam int NW  = pvt_pkg::max2(pvt_pkg::max2(NA, NB), NC) + 1;
    localparam int QB  = C + 1;
    localparam int RW  = NW + QB;
    localparam int DPW = DW - 1;
    localparam int NS  = 8 + QB;
    localparam int OUT = NS - 1;

    localparam logic [QB-1:0] LIM_POS = QB'({(C-1){1'b1}});
    localparam logic [QB-1:0] LIM_NEG = LIM_POS + QB'(1);
    localparam logic [C-1:0]  SAT_HI  = {1'b0, {(C-1){1'b1}}};
    localparam logic [C-1:0]  SAT_LO  = {1'b1, {(C-1){1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers: every write is accepted at once
    // ---------------------------------------------------------------
    logic signed [TW-1:0]              cos_z_reg, sin_z_reg, cos_x_reg, sin_x_reg;
    logic [pvt_pkg::FOCAL_W-1:0]       focal_reg;
    logic [pvt_pkg::EYE_W-1:0]         eye_reg;
    logic [pvt_pkg::CENTER_W-1:0]      cen_x_reg, cen_y_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_z_reg <= pvt_pkg::COS_Z_RST;
            sin_z_reg <= pvt_pkg::SIN_Z_RST;
            cos_x_reg <= pvt_pkg::COS_X_RST;
            sin_x_reg <= pvt_pkg::SIN_X_RST;
            focal_reg <= pvt_pkg::FOCAL_RST;
            eye_reg   <= pvt_pkg::EYE_RST;
            cen_x_reg <= pvt_pkg::CENTER_X_RST;
            cen_y_reg <= pvt_pkg::CENTER_Y_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                pvt_pkg::REG_COS_Z:    cos_z_reg <= cfg.data;
                pvt_pkg::REG_SIN_Z:    sin_z_reg <= cfg.data;
                pvt_pkg::REG_COS_X:    cos_x_reg <= cfg.data;
                pvt_pkg::REG_SIN_X:    sin_x_reg <= cfg.data;
                pvt_pkg::REG_FOCAL:    focal_reg <= cfg.data[pvt_pkg::FOCAL_W-1:0];
                pvt_pkg::REG_EYE_DIST: eye_reg   <= cfg.data[pvt_pkg::EYE_W-1:0];
                pvt_pkg::REG_CENTER_X: cen_x_reg <= cfg.data[pvt_pkg::CENTER_W-1:0];
                pvt_pkg::REG_CENTER_Y: cen_y_reg <= cfg.data[pvt_pkg::CENTER_W-1:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Stage occupancy. A stage loads when it, or any stage after it,
    // is empty, or when the output beat is being taken.
    // ---------------------------------------------------------------
    logic [NS-1:0] v_reg, v_next, move;

    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_move
            assign move[gi] = ~(&v_reg[NS-1:gi]) | screen.ready;
        end
    endgenerate

    always_comb
    begin
        v_next = v_reg;
        if (move[0])
        begin
            v_next[0] = vertex.valid;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (move[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign vertex.ready = move[0];

    // ---------------------------------------------------------------
    // Rotation and projection front end
    // ---------------------------------------------------------------
    logic signed [P1-1:0] x1;
    logic signed [P2-1:0] y2;
    logic signed [DW-1:0] den;

    pvt_rotate #(.C(C), .T(T), .P1(P1), .P2(P2), .DW(DW)) u_rotate (
        .clk     (clk),
        .en      (move[3:0]),
        .vx      (vertex.vertex_x),
        .vy      (vertex.vertex_y),
        .vz      (vertex.vertex_z),
        .cz      (cos_z_reg),
        .sz      (sin_z_reg),
        .cx      (cos_x_reg),
        .sx      (sin_x_reg),
        .ed      (eye_reg),
        .x1_out  (x1),
        .y2_out  (y2),
        .den_out (den)
    );

    logic [RW-1:0]       rem_x [QB+1];
    logic [RW-1:0]       rem_y [QB+1];
    logic [QB-1:0]       q_x   [QB+1];
    logic [QB-1:0]       q_y   [QB+1];
    logic [DPW-1:0]      den_c [QB+1];
    pvt_pkg::div_flags_t flg   [QB+1];

    pvt_project #(.T(T), .P1(P1), .P2(P2), .DW(DW), .NW(NW), .RW(RW), .QB(QB)) u_project (
        .clk      (clk),
        .en       (move[6:4]),
        .x1       (x1),
        .y2       (y2),
        .den      (den),
        .focal    (focal_reg),
        .center_x (cen_x_reg),
        .center_y (cen_y_reg),
        .mag_x    (rem_x[0]),
        .mag_y    (rem_y[0]),
        .den_pos  (den_c[0]),
        .flags    (flg[0])
    );

    assign q_x[0] = '0;
    assign q_y[0] = '0;

    // ---------------------------------------------------------------
    // Divider: one cell per quotient bit, most significant first
    // ---------------------------------------------------------------
    generate
        for (gi = 0; gi < QB; gi++)
        begin : g_cell
            pvt_div_cell #(.RW(RW), .DPW(DPW), .QB(QB), .SHIFT(QB - 1 - gi)) u_cell (
                .clk       (clk),
                .en        (move[7+gi]),
                .rem_x_in  (rem_x[gi]),
                .rem_y_in  (rem_y[gi]),
                .q_x_in    (q_x[gi]),
                .q_y_in    (q_y[gi]),
                .den_in    (den_c[gi]),
                .flags_in  (flg[gi]),
                .rem_x_out (rem_x[gi+1]),
                .rem_y_out (rem_y[gi+1]),
                .q_x_out   (q_x[gi+1]),
                .q_y_out   (q_y[gi+1]),
                .den_out   (den_c[gi+1]),
                .flags_out (flg[gi+1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------
    // Sign, saturation and output register
    // ---------------------------------------------------------------
    pvt_pkg::div_flags_t fin;
    logic [QB-1:0]       qx, qy, nqx, nqy;
    logic [C-1:0]        sx_val, sy_val;
    logic                clip_x, clip_y;
    logic [C-1:0]        sx_reg, sy_reg;
    logic                behind_reg, clip_reg;

    always_comb
    begin
        fin = flg[QB];
        qx  = q_x[QB];
        qy  = q_y[QB];
        nqx = ~qx + QB'(1);
        nqy = ~qy + QB'(1);
        if (fin.neg_x)
        begin
            clip_x = fin.ovf_x || (qx > LIM_NEG);
            sx_val = clip_x ? SAT_LO : nqx[C-1:0];
        end
        else
        begin
            clip_x = fin.ovf_x || (qx > LIM_POS);
            sx_val = clip_x ? SAT_HI : qx[C-1:0];
        end
        if (fin.neg_y)
        begin
            clip_y = fin.ovf_y || (qy > LIM_NEG);
            sy_val = clip_y ? SAT_LO : nqy[C-1:0];
        end
        else
        begin
            clip_y = fin.ovf_y || (qy > LIM_POS);
            sy_val = clip_y ? SAT_HI : qy[C-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (move[OUT])
        begin
            // behind the eye the quotient is dropped: zero coordinates, no clip
            sx_reg     <= fin.behind ? '0 : sx_val;
            sy_reg     <= fin.behind ? '0 : sy_val;
            behind_reg <= fin.behind;
            clip_reg   <= !fin.behind && (clip_x || clip_y);
        end
    end

    assign screen.valid      = v_reg[OUT];
    assign screen.screen_x   = sx_reg;
    assign screen.screen_y   = sy_reg;
    assign screen.behind_eye = behind_reg;
    assign screen.clipped    = clip_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        vertex.valid && vertex.ready |=> v_reg[0])
        else $error("accepted vertex beat not captured");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[OUT] |-> vertex.ready)
        else $error("input stalled with an empty output stage");

    a_behind_clean: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && screen.behind_eye |->
            screen.screen_x == '0 && screen.screen_y == '0 && !screen.clipped)
        else $error("behind-eye beat carries coordinates or clip");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && !screen.ready |=> screen.valid && $stable(sx_reg))
        else $error("stalled result lost");
endmodule

[verif/tb_perspective_vertex_transform.sv]
module tb_perspective_vertex_transform;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW      = pvt_pkg::COORD_WIDTH_DEF;
    localparam int TF      = pvt_pkg::TRIG_FRACTION_BITS_DEF;
    localparam int LATENCY = CW + 9;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic                 behind;
        logic                 clip;
    } screen_t;

    logic clk;
    logic rst_n;

    pvt_cfg_if               cfg_bus ();
    pvt_vertex_if #(.W(CW))  vtx_bus ();
    pvt_screen_if #(.W(CW))  scr_bus ();

    perspective_vertex_transform #(
        .COORD_WIDTH        (CW),
        .TRIG_FRACTION_BITS (TF)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus.sink),
        .vertex (vtx_bus.sink),
        .screen (scr_bus.source)
    );

    // Shadow copy of the transform registers, kept in step with every write
    logic signed [pvt_pkg::TRIG_W-1:0] cos_z_sh, sin_z_sh, cos_x_sh, sin_x_sh;
    logic [pvt_pkg::FOCAL_W-1:0]       focal_sh;
    logic [pvt_pkg::EYE_W-1:0]         eye_sh;
    logic [pvt_pkg::CENTER_W-1:0]      cx_sh, cy_sh;

    vertex_t pending_vertices[$];
    screen_t expected_screens[$];

    int send_idle_pct;
    int recv_stall_pct;
    int failures;

    // set on the rising edge that took the current vertex beat
    logic vtx_taken;

    // ---------------------------------------------------------------------
    // Projection predictor: exact integer arithmetic, one rounding at the end
    // ---------------------------------------------------------------------
    function automatic screen_t project_vertex(vertex_t v);
        longint   tscale, x1, y1, y2, z2, den, nx, ny, qx, qy;
        longint   hi, lo;
        screen_t  r;
        tscale = longint'(1) << TF;
        hi     = (longint'(1) << (CW - 1)) - 1;
        lo     = -hi - 1;
        x1  = longint'(v.x) * cos_z_sh - longint'(v.y) * sin_z_sh;
        y1  = longint'(v.x) * sin_z_sh + longint'(v.y) * cos_z_sh;
        y2  = y1 * cos_x_sh - longint'(v.z) * sin_x_sh * tscale;
        z2  = y1 * sin_x_sh + longint'(v.z) * cos_x_sh * tscale;
        den = z2 + longint'(eye_sh) * tscale * tscale;
        r   = '0;
        if (den <= 0)
        begin
            r.behind = 1'b1;
            return r;
        end
        nx = longint'(focal_sh) * x1 * tscale + longint'(cx_sh) * den;
        ny = longint'(focal_sh) * y2 + longint'(cy_sh) * den;
        // SystemVerilog division truncates toward zero
        qx = nx / den;
        qy = ny / den;
        if (qx > hi)      begin qx = hi; r.clip = 1'b1; end
        else if (qx < lo) begin qx = lo; r.clip = 1'b1; end
        if (qy > hi)      begin qy = hi; r.clip = 1'b1; end
        else if (qy < lo) begin qy = lo; r.clip = 1'b1; end
        r.sx = qx[CW-1:0];
        r.sy = qy[CW-1:0];
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // Vertex driver: advance on falling edges, hold the beat until taken
    // ---------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx_bus.valid    <= 1'b0;
            vtx_bus.vertex_x <= '0;
            vtx_bus.vertex_y <= '0;
            vtx_bus.vertex_z <= '0;
        end
        else if (!vtx_bus.valid || vtx_taken)
        begin
            if (pending_vertices.size() > 0 &&
                $urandom_range(99, 0) >= send_idle_pct)
            begin
                vtx_bus.valid    <= 1'b1;
                vtx_bus.vertex_x <= pending_vertices[0].x;
                vtx_bus.vertex_y <= pending_vertices[0].y;
                vtx_bus.vertex_z <= pending_vertices[0].z;
            end
            else
                vtx_bus.valid <= 1'b0;
        end
    end

    // Work out the expectation on the accepting edge, then drop the item
    always @(posedge clk)
    begin
        vtx_taken <= rst_n && vtx_bus.valid && vtx_bus.ready;
        if (rst_n && vtx_bus.valid && vtx_bus.ready)
        begin
            expected_screens.push_back(project_vertex(pending_vertices[0]));
            void'(pending_vertices.pop_front());
        end
    end

    // Receiver stall pattern, changed on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scr_bus.ready <= 1'b0;
        else
            scr_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Monitor: compare each screen beat with the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        screen_t want;
        if (rst_n && scr_bus.valid && scr_bus.ready)
        begin
            if (expected_screens.size() == 0)
            begin
                $error("screen beat with nothing expected");
                failures++;
            end
            else
            begin
                want = expected_screens.pop_front();
                if (scr_bus.screen_x !== want.sx)
                begin
                    $error("screen_x expected %0d got %0d", want.sx, scr_bus.screen_x);
                    failures++;
                end
                if (scr_bus.screen_y !== want.sy)
                begin
                    $error("screen_y expected %0d got %0d", want.sy, scr_bus.screen_y);
                    failures++;
                end
                if (scr_bus.behind_eye !== want.behind)
                begin
                    $error("behind_eye expected %0b got %0b", want.behind,
                           scr_bus.behind_eye);
                    failures++;
                end
                if (scr_bus.clipped !== want.clip)
                begin
                    $error("clipped expected %0b got %0b", want.clip, scr_bus.clipped);
                    failures++;
                end
            end
        end
    end

    // Register write over the config channel, shadow updated on the same beat
    task automatic write_reg(pvt_pkg::reg_idx_t idx,
                             logic [pvt_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        case (idx)
            pvt_pkg::REG_COS_Z:    cos_z_sh = value;
            pvt_pkg::REG_SIN_Z:    sin_z_sh = value;
            pvt_pkg::REG_COS_X:    cos_x_sh = value;
            pvt_pkg::REG_SIN_X:    sin_x_sh = value;
            pvt_pkg::REG_FOCAL:    focal_sh = value[pvt_pkg::FOCAL_W-1:0];
            pvt_pkg::REG_EYE_DIST: eye_sh   = value;
            pvt_pkg::REG_CENTER_X: cx_sh    = value[pvt_pkg::CENTER_W-1:0];
            pvt_pkg::REG_CENTER_Y: cy_sh    = value[pvt_pkg::CENTER_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all(int cz, int sz, int cx, int sx,
                             int f, int eye, int ox, int oy);
        write_reg(pvt_pkg::REG_COS_Z, cz[15:0]);
        write_reg(pvt_pkg::REG_SIN_Z, sz[15:0]);
        write_reg(pvt_pkg::REG_COS_X, cx[15:0]);
        write_reg(pvt_pkg::REG_SIN_X, sx[15:0]);
        write_reg(pvt_pkg::REG_FOCAL, f[15:0]);
        write_reg(pvt_pkg::REG_EYE_DIST, eye[15:0]);
        write_reg(pvt_pkg::REG_CENTER_X, ox[15:0]);
        write_reg(pvt_pkg::REG_CENTER_Y, oy[15:0]);
    endtask

    // Let the pipeline drain before a register changes
    task automatic drain();
        while (pending_vertices.size() > 0 || expected_screens.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5, 0))
            0:       return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return $signed(16'($urandom_range(2047, 0))) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_trig();
        case ($urandom_range(4, 0))
            0:       return $urandom_range(1, 0) ? 16384 : -16384;
            1:       return $urandom_range(1, 0) ? 32767 : -32768;
            default: return int'($urandom_range(32768, 0)) - 16384;
        endcase
    endfunction

    task automatic push_vertex(int x, int y, int z);
        vertex_t v;
        v.x = x[CW-1:0];
        v.y = y[CW-1:0];
        v.z = z[CW-1:0];
        pending_vertices.push_back(v);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus: directed corners, then random phases across settings
    // ---------------------------------------------------------------------
    initial
    begin
        failures       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cfg_bus.valid  = 1'b0;
        cfg_bus.index  = '0;
        cfg_bus.data   = '0;
        cos_z_sh = pvt_pkg::COS_Z_RST;  sin_z_sh = pvt_pkg::SIN_Z_RST;
        cos_x_sh = pvt_pkg::COS_X_RST;  sin_x_sh = pvt_pkg::SIN_X_RST;
        focal_sh = pvt_pkg::FOCAL_RST;  eye_sh   = pvt_pkg::EYE_RST;
        cx_sh    = pvt_pkg::CENTER_X_RST; cy_sh  = pvt_pkg::CENTER_Y_RST;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset settings: origin, extremes, behind the eye, den zero
        push_vertex(0, 0, 0);
        push_vertex(32767, 32767, 32767);
        push_vertex(-32768, -32768, -32768);
        push_vertex(32767, -32768, 0);
        push_vertex(16, 16, -640);        // den exactly zero
        push_vertex(0, 0, -641);          // just behind the eye
        push_vertex(0, 0, -639);          // just in front, projects onto the centre
        push_vertex(1000, -1000, -600);
        push_vertex(-32768, 32767, 100);
        drain();

        // extremes of every register, trig beyond unity
        write_all(-32768, 32767, 32767, -32768, 4095, 65535, 4095, 4095);
        push_vertex(32767, 32767, 32767);
        push_vertex(-32768, -32768, -32768);
        push_vertex(1, -1, 1);
        push_vertex(0, 0, 0);
        drain();
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        push_vertex(123, -456, 789);     // den zero everywhere
        push_vertex(-1, -1, -1);
        drain();

        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (phase == 0)
                write_all(16384, 0, 16384, 0, 800, 640, 400, 300);
            else
                write_all(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                          $urandom_range(4095, 0),
                          $urandom_range(3, 0) == 0 ? $urandom_range(65535, 0)
                                                    : $urandom_range(8000, 0),
                          $urandom_range(4095, 0), $urandom_range(4095, 0));
            for (int k = 0; k < 128; k++)
            begin
                vertex_t v;
                v.x = rand_coord();
                v.y = rand_coord();
                v.z = rand_coord();
                pending_vertices.push_back(v);
            end
            drain();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
design/pvt_pkg.sv
design/pvt_vertex_if.sv
design/pvt_screen_if.sv
design/pvt_cfg_if.sv
design/pvt_rotate.sv
design/pvt_project.sv
design/pvt_div_cell.sv
design/perspective_vertex_transform.sv
verif/tb_perspective_vertex_transform.sv
